// ----- sv/sfbt_pkg.sv -----
package sfbt_pkg;

  // fixed field widths
  localparam int OP_W      = 3;
  localparam int IN_ADDR_W = 32;
  localparam int SIZE_W    = 20;
  localparam int OFFS_W    = 16;
  localparam int SC_W      = 3;
  localparam int STAT_W    = 2;
  localparam int FOUND_W   = 32;
  localparam int RCNT_W    = 7;
  localparam int RCNT_MAX  = 127;

  // limit registers
  localparam int NUM_LIMITS = 8;
  localparam int LIM_IDX_W  = 3;

  localparam logic [SIZE_W-1:0] LIMIT_RESET [NUM_LIMITS] = '{
    20'd16, 20'd32, 20'd64, 20'd128, 20'd256, 20'd512, 20'd1024, 20'd1048575
  };

  // operation codes
  localparam logic [OP_W-1:0] OP_ADD   = 3'd0;
  localparam logic [OP_W-1:0] OP_RMV   = 3'd1;
  localparam logic [OP_W-1:0] OP_RALL  = 3'd2;
  localparam logic [OP_W-1:0] OP_TAKE  = 3'd3;
  localparam logic [OP_W-1:0] OP_EMPTY = 3'd4;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STAT_W-1:0] ST_MISSING = 2'd2;
  localparam logic [STAT_W-1:0] ST_TOOBIG  = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_CLASS,
    S_FOUND,
    S_SCAN,
    S_MOVE,
    S_DONE
  } state_t;

endpackage

// ----- sv/segregated_free_block_table.sv -----
// Free-block table with per-size-class lists. One operation goes in, one result comes out.
// A sequencer drives a single limit comparator and an entry memory with one write port
// and one registered read port. The class of a size is found by comparing it to one limit
// per cycle, from class 0 up. Remove by address and take scan the class one entry at a
// time, then move the last entry into the hole. Remove all looks at one entry per cycle;
// the cycle that fills a hole also checks the entry moved in. Query empty and out-of-range
// class requests go from the start state straight to done. No new item is taken while one
// is at work, but a finished result waits in the output register while the next transfer
// comes in. Reset clears the class counts at once, so there is no clearing pass. Limit
// registers are written through the cfg port, which is always ready.
module segregated_free_block_table
  import sfbt_pkg::*;
#(
  parameter int NUM_CLASSES       = 8,
  parameter int ENTRIES_PER_CLASS = 64,
  parameter int ADDRESS_WIDTH     = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // input channel
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [OP_W-1:0]      in_operation,
  input  logic [IN_ADDR_W-1:0] in_block_address,
  input  logic [SIZE_W-1:0]    in_block_size,
  input  logic [OFFS_W-1:0]    in_chunk_offset,
  input  logic [SC_W-1:0]      in_size_class,
  // result channel
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [STAT_W-1:0]    out_status,
  output logic [FOUND_W-1:0]   out_found_address,
  output logic [RCNT_W-1:0]    out_removed_count,
  output logic                 out_class_is_empty,
  // limit register writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [LIM_IDX_W-1:0] cfg_index,
  input  logic [SIZE_W-1:0]    cfg_data
);

  // stored address keeps its low ADDRESS_WIDTH bits, never more than the port carries
  localparam int AS    = (ADDRESS_WIDTH < IN_ADDR_W) ? ADDRESS_WIDTH : IN_ADDR_W;
  localparam int IW    = $clog2(ENTRIES_PER_CLASS);
  localparam int CW    = $clog2(ENTRIES_PER_CLASS + 1);
  localparam int CLW   = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int DEPTH = NUM_CLASSES * ENTRIES_PER_CLASS;
  localparam int MAW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int TW    = MAW + CLW + 1;

  // sequencer
  state_t state_r, state_nxt;

  // latched request
  logic [OP_W-1:0]   op_r;
  logic [AS-1:0]     addr_r;
  logic [SIZE_W-1:0] size_r;
  logic [OFFS_W-1:0] offs_r;
  logic [SC_W-1:0]   sc_r;

  // working registers
  logic [CLW-1:0]    cls_r, cls_nxt;
  logic [IW-1:0]     idx_r, idx_nxt;
  logic [STAT_W-1:0] status_r, status_nxt;
  logic [AS-1:0]     found_r, found_nxt;
  logic [CW-1:0]     removed_r, removed_nxt;
  logic              empty_r, empty_nxt;

  // class fill counts and limit registers
  logic [CW-1:0]     count_r   [NUM_CLASSES];
  logic [CW-1:0]     count_nxt [NUM_CLASSES];
  logic [SIZE_W-1:0] limit_r   [NUM_LIMITS];

  // result register
  logic                out_valid_r;
  logic [STAT_W-1:0]   out_status_r;
  logic [FOUND_W-1:0]  out_found_r;
  logic [RCNT_W-1:0]   out_removed_r;
  logic                out_empty_r;

  // memory port
  logic              wr_en, rd_en;
  logic [MAW-1:0]    wr_addr, rd_addr;
  logic [AS-1:0]     rd_blk_addr;
  logic [OFFS_W-1:0] rd_offs;
  logic              addr_hit, offs_hit;

  // derived values
  logic [CW-1:0]     cur_cnt;
  logic [CW-1:0]     last_w;
  logic [IW-1:0]     last_idx;
  logic [IW-1:0]     idx_inc;
  logic [CW-1:0]     idx_p1;
  logic              sc_ok;
  logic [CLW-1:0]    sc_cls;
  logic              size_fits;
  logic              last_class;
  logic              scan_hit;
  logic              in_xfer;
  logic              out_free;
  logic [RCNT_W-1:0] removed_sat;

  function automatic logic [MAW-1:0] slot_addr(input logic [CLW-1:0] c,
                                               input logic [IW-1:0]  i);
    logic [TW-1:0] t;
    t = TW'(c) * TW'(ENTRIES_PER_CLASS) + TW'(i);
    return t[MAW-1:0];
  endfunction

  assign in_ready  = (state_r == S_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_ready;

  assign cur_cnt    = count_r[cls_r];
  assign last_w     = cur_cnt - CW'(1);
  assign last_idx   = last_w[IW-1:0];
  assign idx_inc    = idx_r + IW'(1);
  assign idx_p1     = CW'(idx_r) + CW'(1);
  assign sc_ok      = ({1'b0, sc_r} < (SC_W + 1)'(NUM_CLASSES));
  assign sc_cls     = sc_r[CLW-1:0];
  // the one shared compare: block size against the limit of the class under test
  assign size_fits  = (size_r <= limit_r[LIM_IDX_W'(cls_r)]);
  assign last_class = (cls_r == CLW'(NUM_CLASSES - 1));

  // what counts as a match depends on the operation
  always_comb begin
    unique case (op_r)
      OP_RMV:  scan_hit = addr_hit;
      OP_RALL: scan_hit = offs_hit;
      OP_TAKE: scan_hit = 1'b1;
      default: scan_hit = 1'b0;
    endcase
  end

  // removed count saturates at the field's maximum
  assign removed_sat = ((CW + RCNT_W)'(removed_r) > (CW + RCNT_W)'(RCNT_MAX)) ?
                       RCNT_W'(RCNT_MAX) : RCNT_W'(removed_r);

  sfbt_entry_store #(
    .AS    (AS),
    .DEPTH (DEPTH),
    .MAW   (MAW)
  ) u_store (
    .clk         (clk),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_blk_addr ((state_r == S_MOVE) ? rd_blk_addr : addr_r),
    .wr_offs     ((state_r == S_MOVE) ? rd_offs : offs_r),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .key_addr    (addr_r),
    .key_offs    (offs_r),
    .rd_blk_addr (rd_blk_addr),
    .rd_offs     (rd_offs),
    .addr_hit    (addr_hit),
    .offs_hit    (offs_hit)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) state_nxt = S_START;
      end
      S_START: begin
        priority if (op_r == OP_ADD || op_r == OP_RMV || op_r == OP_TAKE) begin
          state_nxt = S_CLASS;
        end else if (op_r == OP_RALL && sc_ok) begin
          state_nxt = S_FOUND;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_CLASS: begin
        if (size_fits || last_class) state_nxt = size_fits ? S_FOUND : S_DONE;
      end
      S_FOUND: begin
        if (op_r == OP_ADD || cur_cnt == '0) state_nxt = S_DONE;
        else state_nxt = S_SCAN;
      end
      S_SCAN: begin
        priority if (scan_hit) state_nxt = S_MOVE;
        else if (idx_p1 < cur_cnt) state_nxt = S_SCAN;
        else state_nxt = S_DONE;
      end
      S_MOVE: begin
        priority if (op_r != OP_RALL) state_nxt = S_DONE;
        else if (CW'(idx_r) < last_w && offs_hit) state_nxt = S_MOVE;
        else if (idx_p1 < last_w) state_nxt = S_SCAN;
        else state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    cls_nxt     = cls_r;
    idx_nxt     = idx_r;
    status_nxt  = status_r;
    found_nxt   = found_r;
    removed_nxt = removed_r;
    empty_nxt   = empty_r;
    count_nxt   = count_r;
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    wr_addr     = '0;
    rd_addr     = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          status_nxt  = ST_OK;
          found_nxt   = '0;
          removed_nxt = '0;
          empty_nxt   = 1'b0;
          cls_nxt     = '0;
          idx_nxt     = '0;
        end
      end
      S_START: begin
        if (op_r == OP_RALL) begin
          if (sc_ok) cls_nxt = sc_cls;
          else status_nxt = ST_MISSING;
        end else if (op_r == OP_EMPTY) begin
          if (sc_ok) begin
            empty_nxt = (count_r[sc_cls] == '0);
          end else begin
            status_nxt = ST_MISSING;
            empty_nxt  = 1'b1;
          end
        end
      end
      S_CLASS: begin
        if (!size_fits) begin
          if (last_class) status_nxt = ST_TOOBIG;
          else cls_nxt = cls_r + CLW'(1);
        end
      end
      S_FOUND: begin
        if (op_r == OP_ADD) begin
          if (cur_cnt == CW'(ENTRIES_PER_CLASS)) begin
            status_nxt = ST_FULL;
          end else begin
            wr_en             = 1'b1;
            wr_addr           = slot_addr(cls_r, cur_cnt[IW-1:0]);
            count_nxt[cls_r]  = cur_cnt + CW'(1);
          end
        end else if (cur_cnt == '0) begin
          // empty class: remove all just reports nothing deleted
          if (op_r != OP_RALL) status_nxt = ST_MISSING;
        end else begin
          rd_en   = 1'b1;
          rd_addr = slot_addr(cls_r, '0);
          idx_nxt = '0;
        end
      end
      S_SCAN: begin
        if (scan_hit) begin
          if (op_r == OP_TAKE) found_nxt = rd_blk_addr;
          // fetch the last entry to fill the hole
          rd_en   = 1'b1;
          rd_addr = slot_addr(cls_r, last_idx);
        end else if (idx_p1 < cur_cnt) begin
          rd_en   = 1'b1;
          rd_addr = slot_addr(cls_r, idx_inc);
          idx_nxt = idx_inc;
        end else if (op_r == OP_RMV) begin
          status_nxt = ST_MISSING;
        end
      end
      S_MOVE: begin
        // last entry lands in the hole and the class shrinks
        wr_en            = 1'b1;
        wr_addr          = slot_addr(cls_r, idx_r);
        count_nxt[cls_r] = last_w;
        removed_nxt      = removed_r + CW'(1);
        if (op_r == OP_RALL) begin
          if (CW'(idx_r) < last_w && offs_hit) begin
            // moved entry matches too: drop it against the new last entry
            rd_en   = 1'b1;
            rd_addr = slot_addr(cls_r, last_w[IW-1:0] - IW'(1));
          end else if (idx_p1 < last_w) begin
            rd_en   = 1'b1;
            rd_addr = slot_addr(cls_r, idx_inc);
            idx_nxt = idx_inc;
          end
        end
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // request latch, payload only, and the working registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_r   <= in_operation;
      addr_r <= in_block_address[AS-1:0];
      size_r <= in_block_size;
      offs_r <= in_chunk_offset;
      sc_r   <= in_size_class;
    end
    cls_r     <= cls_nxt;
    idx_r     <= idx_nxt;
    status_r  <= status_nxt;
    found_r   <= found_nxt;
    removed_r <= removed_nxt;
    empty_r   <= empty_nxt;
  end

  // control state, counts and limits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      for (int c = 0; c < NUM_CLASSES; c++) begin
        count_r[c] <= '0;
      end
      limit_r <= LIMIT_RESET;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (cfg_valid && cfg_ready) begin
        limit_r[cfg_index] <= cfg_data;
      end
    end
  end

  // result register, loaded when the result slot is free
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DONE && out_free) begin
      out_status_r  <= status_r;
      out_found_r   <= FOUND_W'(found_r);
      out_removed_r <= (op_r == OP_RALL) ? removed_sat : '0;
      out_empty_r   <= empty_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_found_address  = out_found_r;
  assign out_removed_count  = out_removed_r;
  assign out_class_is_empty = out_empty_r;

endmodule

// ----- sv/sfbt_entry_store.sv -----
module sfbt_entry_store
  import sfbt_pkg::*;
#(
  parameter int AS    = 32,
  parameter int DEPTH = 512,
  parameter int MAW   = 9
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [MAW-1:0]    wr_addr,
  input  logic [AS-1:0]     wr_blk_addr,
  input  logic [OFFS_W-1:0] wr_offs,
  input  logic              rd_en,
  input  logic [MAW-1:0]    rd_addr,
  input  logic [AS-1:0]     key_addr,
  input  logic [OFFS_W-1:0] key_offs,
  output logic [AS-1:0]     rd_blk_addr,
  output logic [OFFS_W-1:0] rd_offs,
  output logic              addr_hit,
  output logic              offs_hit
);

  logic [AS+OFFS_W-1:0] store_r [DEPTH];
  logic [AS+OFFS_W-1:0] rd_q_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_r[wr_addr] <= {wr_blk_addr, wr_offs};
    end
    if (rd_en) begin
      rd_q_r <= store_r[rd_addr];
    end
  end

  assign rd_blk_addr = rd_q_r[AS+OFFS_W-1:OFFS_W];
  assign rd_offs     = rd_q_r[OFFS_W-1:0];

  // key compare against the entry just read
  assign addr_hit = (rd_blk_addr == key_addr);
  assign offs_hit = (rd_offs == key_offs);

endmodule

// ----- sim/segregated_free_block_table_tb.sv -----
`timescale 1ns / 1ps

module segregated_free_block_table_tb;
  import sfbt_pkg::*;

  localparam int NUM_CLASSES       = 8;
  localparam int ENTRIES_PER_CLASS = 64;
  localparam int ADDRESS_WIDTH     = 32;

  // codes above the last defined operation are unknown and must do nothing
  localparam int OP_LAST_CODE = (1 << OP_W) - 1;
  localparam int SC_LAST      = (1 << SC_W) - 1;
  localparam int SIZE_MAX     = (1 << SIZE_W) - 1;

  // class filled up to the brim in the full-class test
  localparam int FILL_CLASS = 3;

  // one of the slowest transfer-to-result times is a remove that scans a full top class
  localparam int TAIL_CYCLES = 200;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic [OP_W-1:0]      op;
    logic [IN_ADDR_W-1:0] blk_addr;
    logic [SIZE_W-1:0]    blk_size;
    logic [OFFS_W-1:0]    chunk_offs;
    logic [SC_W-1:0]      cls_idx;
  } table_req_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [FOUND_W-1:0] found_addr;
    logic [RCNT_W-1:0]  removed;
    logic               is_empty;
  } table_rsp_t;

  typedef struct packed {
    logic [ADDRESS_WIDTH-1:0] addr;
    logic [SIZE_W-1:0]        blk_size;
    logic [OFFS_W-1:0]        chunk_offs;
  } free_entry_t;

  // clock, reset and every block input start at known values
  logic                 clk                = 1'b0;
  logic                 rst_n              = 1'b0;
  logic                 in_valid           = 1'b0;
  logic                 in_ready;
  logic [OP_W-1:0]      in_operation       = '0;
  logic [IN_ADDR_W-1:0] in_block_address   = '0;
  logic [SIZE_W-1:0]    in_block_size      = '0;
  logic [OFFS_W-1:0]    in_chunk_offset    = '0;
  logic [SC_W-1:0]      in_size_class      = '0;
  logic                 out_valid;
  logic                 out_ready          = 1'b0;
  logic [STAT_W-1:0]    out_status;
  logic [FOUND_W-1:0]   out_found_address;
  logic [RCNT_W-1:0]    out_removed_count;
  logic                 out_class_is_empty;
  logic                 cfg_valid          = 1'b0;
  logic                 cfg_ready;
  logic [LIM_IDX_W-1:0] cfg_index          = '0;
  logic [SIZE_W-1:0]    cfg_data           = '0;

  // shadow copy of the table: limits, per-class slots and fill levels
  logic [SIZE_W-1:0] class_limit [NUM_LIMITS];
  free_entry_t       slot_mem    [NUM_CLASSES][ENTRIES_PER_CLASS];
  int unsigned       class_fill  [NUM_CLASSES];

  // results still owed by the block, oldest first
  table_rsp_t rsp_expected [$];

  int error_count    = 0;
  int send_idle_pct  = 29;
  int recv_idle_pct  = 87;

  segregated_free_block_table #(
    .NUM_CLASSES       (NUM_CLASSES),
    .ENTRIES_PER_CLASS (ENTRIES_PER_CLASS),
    .ADDRESS_WIDTH     (ADDRESS_WIDTH)
  ) u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_operation       (in_operation),
    .in_block_address   (in_block_address),
    .in_block_size      (in_block_size),
    .in_chunk_offset    (in_chunk_offset),
    .in_size_class      (in_size_class),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_found_address  (out_found_address),
    .out_removed_count  (out_removed_count),
    .out_class_is_empty (out_class_is_empty),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    foreach (class_limit[i]) class_limit[i] = LIMIT_RESET[i];
    foreach (class_fill[i]) class_fill[i] = 0;
  end

  // ---------------------------------------------------------------------------
  // table model
  // ---------------------------------------------------------------------------

  // first class whose limit covers the size; limits need not be increasing
  function automatic int class_for_size(input logic [SIZE_W-1:0] sz);
    for (int c = 0; c < NUM_CLASSES && c < NUM_LIMITS; c++)
      if (sz <= class_limit[c]) return c;
    return -1;
  endfunction

  // last entry of the class moves into the hole
  function automatic void drop_entry(input int cls, input int idx);
    slot_mem[cls][idx] = slot_mem[cls][class_fill[cls] - 1];
    class_fill[cls]--;
  endfunction

  // applies one accepted request to the shadow table and returns its result
  function automatic table_rsp_t apply_request(input table_req_t r);
    table_rsp_t rsp;
    int         cls;
    int         i;
    int         hits;
    rsp  = '0;
    hits = 0;
    case (r.op)
      OP_ADD: begin
        cls = class_for_size(r.blk_size);
        if (cls < 0) begin
          rsp.status = ST_TOOBIG;
        end else if (class_fill[cls] >= ENTRIES_PER_CLASS) begin
          rsp.status = ST_FULL;
        end else begin
          slot_mem[cls][class_fill[cls]] = '{addr: ADDRESS_WIDTH'(r.blk_addr),
                                             blk_size: r.blk_size,
                                             chunk_offs: r.chunk_offs};
          class_fill[cls]++;
        end
      end
      OP_RMV: begin
        cls = class_for_size(r.blk_size);
        if (cls < 0) begin
          rsp.status = ST_TOOBIG;
        end else begin
          i = 0;
          while (i < class_fill[cls] && slot_mem[cls][i].addr != ADDRESS_WIDTH'(r.blk_addr))
            i++;
          if (i >= class_fill[cls]) rsp.status = ST_MISSING;
          else drop_entry(cls, i);
        end
      end
      OP_RALL: begin
        if (r.cls_idx >= NUM_CLASSES) begin
          rsp.status = ST_MISSING;
        end else begin
          // the entry swapped into a hole is looked at again
          i = 0;
          while (i < class_fill[r.cls_idx]) begin
            if (slot_mem[r.cls_idx][i].chunk_offs == r.chunk_offs) begin
              drop_entry(r.cls_idx, i);
              hits++;
            end else begin
              i++;
            end
          end
          rsp.removed = (hits > RCNT_MAX) ? RCNT_W'(RCNT_MAX) : RCNT_W'(hits);
        end
      end
      OP_TAKE: begin
        cls = class_for_size(r.blk_size);
        if (cls < 0) begin
          rsp.status = ST_TOOBIG;
        end else if (class_fill[cls] == 0) begin
          rsp.status = ST_MISSING;
        end else begin
          rsp.found_addr = FOUND_W'(slot_mem[cls][0].addr);
          drop_entry(cls, 0);
        end
      end
      OP_EMPTY: begin
        if (r.cls_idx >= NUM_CLASSES) begin
          rsp.status   = ST_MISSING;
          rsp.is_empty = 1'b1;
        end else begin
          rsp.is_empty = (class_fill[r.cls_idx] == 0);
        end
      end
      default: ;
    endcase
    return rsp;
  endfunction

  // ---------------------------------------------------------------------------
  // channel drivers and result checker
  // ---------------------------------------------------------------------------

  function automatic table_req_t make_req(input logic [OP_W-1:0] op,
                                          input logic [IN_ADDR_W-1:0] addr,
                                          input logic [SIZE_W-1:0] sz,
                                          input logic [OFFS_W-1:0] offs,
                                          input logic [SC_W-1:0] cls);
    table_req_t r;
    r = '{op: op, blk_addr: addr, blk_size: sz, chunk_offs: offs, cls_idx: cls};
    return r;
  endfunction

  // one request transfer; the expected result is computed when it is taken
  task automatic send_item(input table_req_t r);
    // random idle gap before raising valid, valid stays put once high
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid         <= 1'b1;
    in_operation     <= r.op;
    in_block_address <= r.blk_addr;
    in_block_size    <= r.blk_size;
    in_chunk_offset  <= r.chunk_offs;
    in_size_class    <= r.cls_idx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    rsp_expected.push_back(apply_request(r));
  endtask

  // drop valid and wait until every owed result has been taken
  task automatic wait_table_idle();
    in_valid <= 1'b0;
    while (rsp_expected.size() != 0) @(posedge clk);
  endtask

  // write all limit registers back to back; only called with the table idle
  task automatic load_class_limits(input logic [SIZE_W-1:0] lim [NUM_LIMITS]);
    for (int i = 0; i < NUM_LIMITS; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= LIM_IDX_W'(i);
      cfg_data  <= lim[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      class_limit[i] = lim[i];
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic void check_result(input table_rsp_t got);
    table_rsp_t want;
    if (rsp_expected.size() == 0) begin
      error_count++;
      if (error_count <= 10)
        $display("unexpected result: status %0d found %h removed %0d empty %0d",
                 got.status, got.found_addr, got.removed, got.is_empty);
      return;
    end
    want = rsp_expected.pop_front();
    if (got.status !== want.status || got.found_addr !== want.found_addr ||
        got.removed !== want.removed || got.is_empty !== want.is_empty) begin
      error_count++;
      if (error_count <= 10)
        $display("mismatch (exp/act): status %0d/%0d found %h/%h removed %0d/%0d empty %0d/%0d",
                 want.status, got.status, want.found_addr, got.found_addr,
                 want.removed, got.removed, want.is_empty, got.is_empty);
    end
  endfunction

  // result side: check every transfer, stall ready at random
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      check_result('{status: out_status, found_addr: out_found_address,
                     removed: out_removed_count, is_empty: out_class_is_empty});
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // ---------------------------------------------------------------------------
  // random stimulus
  // ---------------------------------------------------------------------------

  // sizes at and just above the limits, plus random, maximal and small ones, so class edges and oversize both show up
  function automatic logic [SIZE_W-1:0] pick_size();
    int k;
    k = $urandom_range(0, NUM_LIMITS - 1);
    case ($urandom_range(0, 5))
      0:       return class_limit[k];
      1:       return class_limit[k] + 1'b1;
      2:       return SIZE_W'($urandom_range(0, class_limit[k]));
      3:       return SIZE_W'($urandom());
      4:       return SIZE_W'(SIZE_MAX);
      default: return SIZE_W'($urandom_range(0, 64));
    endcase
  endfunction

  // small offset pool so remove-all finds several matches
  function automatic logic [OFFS_W-1:0] pick_offset();
    if ($urandom_range(0, 9) < 7) return OFFS_W'($urandom_range(0, 3));
    return OFFS_W'($urandom());
  endfunction

  function automatic int any_filled_class();
    int start;
    start = $urandom_range(0, NUM_CLASSES - 1);
    for (int k = 0; k < NUM_CLASSES; k++)
      if (class_fill[(start + k) % NUM_CLASSES] != 0) return (start + k) % NUM_CLASSES;
    return -1;
  endfunction

  // removes mostly aim at stored entries; the rest are misses and noise
  function automatic table_req_t make_random_req(input int add_pct);
    table_req_t r;
    int         cls;
    int         slot;
    int         pick;
    r = make_req(OP_ADD, $urandom(), pick_size(), pick_offset(),
                 SC_W'($urandom_range(0, SC_LAST)));
    if ($urandom_range(0, 99) >= add_pct) begin
      pick = $urandom_range(0, 99);
      cls  = any_filled_class();
      slot = (cls < 0) ? 0 : $urandom_range(0, class_fill[cls] - 1);
      if (pick < 35) begin
        r.op = OP_RMV;
        if (cls >= 0 && $urandom_range(0, 9) < 8) begin
          r.blk_addr = IN_ADDR_W'(slot_mem[cls][slot].addr);
          r.blk_size = slot_mem[cls][slot].blk_size;
        end
      end else if (pick < 50) begin
        r.op = OP_RALL;
        if (cls >= 0 && $urandom_range(0, 3) != 0) begin
          r.cls_idx    = SC_W'(cls);
          r.chunk_offs = slot_mem[cls][slot].chunk_offs;
        end
      end else if (pick < 78) begin
        r.op = OP_TAKE;
      end else if (pick < 95) begin
        r.op = OP_EMPTY;
      end else begin
        r.op = OP_W'($urandom_range(OP_EMPTY + 1, OP_LAST_CODE));
      end
    end
    return r;
  endfunction

  task automatic run_random_items(input int n_items, input int add_pct);
    repeat (n_items) send_item(make_random_req(add_pct));
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // every operation at reset limits, field extremes, misses and the remove-all recheck
  task automatic test_basic_ops();
    logic [IN_ADDR_W-1:0] addr_a;
    logic [IN_ADDR_W-1:0] addr_b;
    addr_a = $urandom();
    addr_b = $urandom();
    // empty table: queries, take and remove find nothing
    send_item(make_req(OP_EMPTY, '0, '0, '0, '0));
    send_item(make_req(OP_EMPTY, '1, '1, '1, SC_W'(SC_LAST)));
    send_item(make_req(OP_TAKE, '0, '0, '0, '0));
    send_item(make_req(OP_RMV, addr_a, SIZE_W'(100), '0, '0));
    send_item(make_req(OP_RALL, '0, '0, '0, SC_W'(2)));
    // all-zero and all-ones entries, plus the class 0/1 boundary
    send_item(make_req(OP_ADD, '0, '0, '0, '0));
    send_item(make_req(OP_ADD, '1, '1, '1, '0));
    send_item(make_req(OP_ADD, addr_a, SIZE_W'(16), OFFS_W'(1), '0));
    send_item(make_req(OP_ADD, addr_b, SIZE_W'(17), OFFS_W'(1), '0));
    // class 2 holds offsets 5 5 6 5, so the swapped-in entry must be rechecked
    send_item(make_req(OP_ADD, $urandom(), SIZE_W'(33), OFFS_W'(5), '0));
    send_item(make_req(OP_ADD, $urandom(), SIZE_W'(40), OFFS_W'(5), '0));
    send_item(make_req(OP_ADD, $urandom(), SIZE_W'(50), OFFS_W'(6), '0));
    send_item(make_req(OP_ADD, $urandom(), SIZE_W'(64), OFFS_W'(5), '0));
    send_item(make_req(OP_RALL, '0, '0, OFFS_W'(5), SC_W'(2)));
    send_item(make_req(OP_EMPTY, '0, '0, '0, SC_W'(2)));
    send_item(make_req(OP_RALL, '0, '0, OFFS_W'(6), SC_W'(2)));
    // no match left
    send_item(make_req(OP_RALL, '0, '0, OFFS_W'(6), SC_W'(2)));
    // remove by address, then the same address again misses
    send_item(make_req(OP_RMV, addr_a, SIZE_W'(16), '0, '0));
    send_item(make_req(OP_RMV, addr_a, SIZE_W'(16), '0, '0));
    // take the largest block, then class 7 is empty again
    send_item(make_req(OP_TAKE, '0, '1, '0, '0));
    send_item(make_req(OP_EMPTY, '0, '0, '0, SC_W'(SC_LAST)));
    send_item(make_req(OP_TAKE, '0, SIZE_W'(5), '0, '0));
    // unknown codes leave the table alone
    for (int code = OP_EMPTY + 1; code <= OP_LAST_CODE; code++)
      send_item(make_req(OP_W'(code), '1, '1, '1, SC_W'(SC_LAST)));
  endtask

  // fill one class to capacity, one more add reports full, then clear it in one go
  task automatic test_fill_to_full();
    logic [OFFS_W-1:0] fill_offs;
    fill_offs = $urandom();
    repeat (ENTRIES_PER_CLASS + 1)
      send_item(make_req(OP_ADD, $urandom(),
                         SIZE_W'($urandom_range(class_limit[FILL_CLASS - 1] + 1,
                                                class_limit[FILL_CLASS])),
                         fill_offs, '0));
    send_item(make_req(OP_EMPTY, '0, '0, '0, SC_W'(FILL_CLASS)));
    send_item(make_req(OP_RALL, '0, '0, fill_offs, SC_W'(FILL_CLASS)));
    send_item(make_req(OP_EMPTY, '0, '0, '0, SC_W'(FILL_CLASS)));
  endtask

  // top limit lowered so the largest sizes fit no class
  task automatic test_oversize();
    logic [SIZE_W-1:0] plan [NUM_LIMITS];
    foreach (plan[i]) plan[i] = LIMIT_RESET[i];
    plan[NUM_LIMITS - 1] = SIZE_W'(1000);
    wait_table_idle();
    load_class_limits(plan);
    send_item(make_req(OP_ADD, $urandom(), '1, $urandom(), '0));
    send_item(make_req(OP_RMV, $urandom(), '1, '0, '0));
    send_item(make_req(OP_TAKE, '0, SIZE_W'(1001), '0, '0));
  endtask

  // slow receiver: reset limits, then every limit at zero
  task automatic test_random_default_limits();
    logic [SIZE_W-1:0] plan [NUM_LIMITS];
    wait_table_idle();
    foreach (plan[i]) plan[i] = LIMIT_RESET[i];
    load_class_limits(plan);
    run_random_items(200, 55);
    wait_table_idle();
    foreach (plan[i]) plan[i] = '0;
    load_class_limits(plan);
    run_random_items(100, 50);
  endtask

  // slow sender: every limit at max (all in class 0, fills fast), then scrambled limits
  task automatic test_random_wide_limits();
    logic [SIZE_W-1:0] plan [NUM_LIMITS];
    wait_table_idle();
    send_idle_pct = 87;
    recv_idle_pct = 29;
    foreach (plan[i]) plan[i] = '1;
    load_class_limits(plan);
    run_random_items(150, 60);
    wait_table_idle();
    foreach (plan[i])
      plan[i] = ($urandom_range(0, 1) != 0) ? SIZE_W'($urandom()) : SIZE_W'($urandom_range(0, 2048));
    load_class_limits(plan);
    run_random_items(250, 45);
  endtask

  // back to back on both sides: doubling limits, then reset limits again
  task automatic test_random_no_idle();
    logic [SIZE_W-1:0] plan [NUM_LIMITS];
    wait_table_idle();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    foreach (plan[i]) plan[i] = SIZE_W'(4 << i);
    plan[NUM_LIMITS - 1] = SIZE_W'($urandom_range(600, SIZE_MAX));
    load_class_limits(plan);
    run_random_items(250, 50);
    wait_table_idle();
    foreach (plan[i]) plan[i] = LIMIT_RESET[i];
    load_class_limits(plan);
    run_random_items(250, 40);
  endtask

  // ---------------------------------------------------------------------------
  // sequence and end of run
  // ---------------------------------------------------------------------------

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_basic_ops();
    test_fill_to_full();
    test_oversize();
    test_random_default_limits();
    test_random_wide_limits();
    test_random_no_idle();
    wait_table_idle();
    // anything arriving now is a stray result
    repeat (TAIL_CYCLES) @(posedge clk);
    error_count += rsp_expected.size();
    if (error_count == 0) begin
      $display("segregated_free_block_table_tb: done, clean");
    end else begin
      $display("segregated_free_block_table_tb: done, errors");
    end
    $finish;
  end

  // hang guard
  initial begin : watchdog
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("segregated_free_block_table_tb: done, errors");
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/sfbt_pkg.sv
sv/sfbt_entry_store.sv
sv/segregated_free_block_table.sv
sim/segregated_free_block_table_tb.sv
